// ===== rtl/core/akrt_pkg.sv =====
// Shared constants, register index codes and the configuration record of
// the analog key rapid trigger block. Depends on nothing.
package akrt_pkg;

    // Fixed point set-up: sample width and fraction bits of the position.
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    // Derived widths.
    localparam int ZP_W   = 16;                 // zero point register width
    localparam int DIFF_W = ZP_W + 1;           // zero_point - raw_sample
    localparam int SCL_W  = 32;                 // reciprocal scale width
    localparam int PROD_W = DIFF_W + SCL_W + 1; // signed product width
    localparam int POS_W  = FRACTION_BITS + 2;  // saturated position width
    localparam int WIDE_W = POS_W + 3;          // room for position sums
    localparam int SPD_W  = 19;                 // speed threshold width
    localparam int HYS_W  = 17;
    localparam int RLS_W  = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE          = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DISTANCE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_DISTANCE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SPEED    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_SPEED     = 4'd7;

    // Trigger modes; the fourth code holds all state.
    localparam logic [1:0] MODE_THRESHOLD = 2'd0;
    localparam logic [1:0] MODE_RAPID     = 2'd1;
    localparam logic [1:0] MODE_SPEED     = 2'd2;

    // Position constants.
    localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(2 ** FRACTION_BITS);

    typedef struct packed {
        logic        [1:0]        mode;
        logic signed [ZP_W-1:0]   zero_point;
        logic        [SCL_W-1:0]  scale;
        logic        [HYS_W-1:0]  hysteresis;
        logic signed [POS_W-1:0]  press_distance;
        logic        [RLS_W-1:0]  lift_distance;
        logic signed [SPD_W-1:0]  press_speed;
        logic signed [SPD_W-1:0]  lift_speed;
    } akrt_cfg_t;

endpackage

// ===== rtl/core/akrt_norm.sv =====
// Position normalizer: (zero_point - raw_sample) * scale, floor shift and
// saturation. Depends on akrt_pkg.
module akrt_norm (
    input  logic signed [akrt_pkg::SAMPLE_BITS-1:0] raw,
    input  akrt_pkg::akrt_cfg_t                     cfg,
    output logic signed [akrt_pkg::POS_W-1:0]       pos
);
    import akrt_pkg::*;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(2 ** (POS_W - 1));

    logic signed [DIFF_W-1:0] diff;
    logic signed [SCL_W:0]    scale_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;

    always_comb
    begin
        diff    = DIFF_W'($signed(cfg.zero_point)) - DIFF_W'(raw);
        scale_s = $signed({1'b0, cfg.scale});
        prod    = PROD_W'(diff) * PROD_W'(scale_s);
        // Arithmetic shift rounds toward minus infinity.
        shifted = prod >>> FRACTION_BITS;
        if (shifted > SAT_HI)
        begin
            pos = SAT_HI[POS_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            pos = SAT_LO[POS_W-1:0];
        end
        else
        begin
            pos = shifted[POS_W-1:0];
        end
    end

endmodule

// ===== rtl/core/akrt_trig.sv =====
// Trigger state: threshold, rapid trigger and speed modes with the key
// state, last position and travel extremes. Depends on akrt_pkg.
module akrt_trig (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  akrt_pkg::akrt_cfg_t                cfg,
    input  logic signed [akrt_pkg::POS_W-1:0]  pos,
    output logic                               pressed_next,
    output logic                               edge_next
);
    import akrt_pkg::*;

    logic                     key_down_reg, key_down_next;
    logic signed [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic signed [POS_W-1:0]  tmin_reg, tmin_next;
    logic signed [POS_W-1:0]  tmax_reg, tmax_next;

    logic signed [WIDE_W-1:0] pos_w, hys_w, pd_w, rd_w, tmin_w, tmax_w, tmax1_w;
    logic signed [WIDE_W-1:0] ps_w, rs_w, delta_w;
    logic                     rise, fall;
    logic signed [POS_W-1:0]  tmax1;

    always_comb
    begin
        pos_w   = WIDE_W'(pos);
        hys_w   = WIDE_W'($signed({1'b0, cfg.hysteresis}));
        pd_w    = WIDE_W'($signed(cfg.press_distance));
        rd_w    = WIDE_W'($signed({1'b0, cfg.lift_distance}));
        tmin_w  = WIDE_W'(tmin_reg);
        tmax_w  = WIDE_W'(tmax_reg);
        ps_w    = WIDE_W'($signed(cfg.press_speed));
        rs_w    = WIDE_W'($signed(cfg.lift_speed));
        delta_w = pos_w - WIDE_W'(last_pos_reg);

        key_down_next = key_down_reg;
        last_pos_next = last_pos_reg;
        tmin_next     = tmin_reg;
        tmax_next     = tmax_reg;

        rise  = (pos_w - tmin_w - hys_w) >= pd_w;
        // The release test sees the maximum as already updated by the press test.
        if (key_down_reg)
        begin
            tmax1 = (rise && pos > tmax_reg) ? pos : tmax_reg;
        end
        else
        begin
            tmax1 = rise ? pos : tmax_reg;
        end
        tmax1_w = WIDE_W'(tmax1);
        fall    = (tmax1_w - pos_w - hys_w) >= rd_w;

        case (cfg.mode)
            MODE_THRESHOLD:
            begin
                if (pos_w - hys_w > pd_w)
                begin
                    key_down_next = 1'b1;
                end
                if (pos_w + hys_w < pd_w)
                begin
                    key_down_next = 1'b0;
                end
                last_pos_next = pos;
            end
            MODE_RAPID:
            begin
                tmax_next = tmax1;
                if (key_down_reg)
                begin
                    if (fall)
                    begin
                        tmin_next     = pos;
                        key_down_next = 1'b0;
                    end
                end
                else
                begin
                    if (rise)
                    begin
                        key_down_next = 1'b1;
                    end
                    if (fall && pos < tmin_reg)
                    begin
                        tmin_next = pos;
                    end
                end
                // Out-of-range travel forces the state.
                if (pos < 0)
                begin
                    key_down_next = 1'b0;
                    tmin_next     = '0;
                end
                if (pos >= POS_ONE)
                begin
                    key_down_next = 1'b1;
                    tmax_next     = POS_ONE;
                end
                last_pos_next = pos;
            end
            MODE_SPEED:
            begin
                if (delta_w > ps_w)
                begin
                    key_down_next = 1'b1;
                end
                if (delta_w < rs_w)
                begin
                    key_down_next = 1'b0;
                end
                last_pos_next = pos;
            end
            default:
            begin
                key_down_next = key_down_reg;
            end
        endcase

        pressed_next = key_down_next;
        edge_next    = key_down_next & ~key_down_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg <= 1'b0;
            last_pos_reg <= '0;
            tmin_reg     <= '0;
            tmax_reg     <= '0;
        end
        else if (step)
        begin
            key_down_reg <= key_down_next;
            last_pos_reg <= last_pos_next;
            tmin_reg     <= tmin_next;
            tmax_reg     <= tmax_next;
        end
    end

endmodule

// ===== rtl/core/analog_key_rapid_trigger.sv =====
// Top level of the analog key rapid trigger block: configuration registers,
// the two-register sample pipeline, whose second register is the output register.
// Depends on akrt_pkg, akrt_norm and akrt_trig.

// Each accepted raw_sample transaction gives exactly one result transaction
// carrying pressed, press_edge and position, in order. A sample passes two
// registers: the input register, and the result register that takes the
// output of the multiplier, saturation and trigger logic in one pass. A
// result passes from the input register to the result register, and one
// sample is taken every cycle, while the output is not stalled. The key
// state, travel extremes and last position are read and written once per
// sample in the same cycle, so back-to-back samples never wait on one
// another. Stall from the output side reaches the input within the same
// cycle once both registers hold a sample; an empty register still fills.
// Configuration writes are always accepted (cfg_ready is high) and must be
// made only while no sample is in flight; an index beyond the eight
// registers is ignored.
module analog_key_rapid_trigger (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [akrt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [akrt_pkg::CFG_DATA_W-1:0]         cfg_data,
    // Sample input channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [akrt_pkg::SAMPLE_BITS-1:0] raw_sample,
    // Result output channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    pressed,
    output logic                                    press_edge,
    output logic signed [akrt_pkg::POS_W-1:0]       position
);
    import akrt_pkg::*;

    akrt_cfg_t cfg_reg;

    // Pipeline registers.
    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] raw_reg;
    logic                          out_valid_reg;
    logic                          pressed_reg;
    logic                          edge_reg;
    logic signed [POS_W-1:0]       position_reg;

    logic                          ready_out, ready_a;
    logic                          load_a, load_out;
    logic signed [POS_W-1:0]       pos_next;
    logic                          pressed_next, edge_next;

    // Each stage loads when it is empty or its contents move on.
    assign ready_out = ~out_valid_reg | ~out_stall;
    assign ready_a   = ~a_valid_reg | ready_out;
    assign load_a    = ready_a;
    assign load_out  = ready_out;

    assign in_stall  = ~ready_a;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_THRESHOLD;
            cfg_reg.zero_point     <= '0;
            cfg_reg.scale          <= SCL_W'(65536);
            cfg_reg.hysteresis     <= '0;
            cfg_reg.press_distance <= POS_W'(32768);
            cfg_reg.lift_distance  <= RLS_W'(32768);
            cfg_reg.press_speed    <= SPD_W'(4096);
            cfg_reg.lift_speed     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:           cfg_reg.mode           <= cfg_data[1:0];
                CFG_ZERO_POINT:     cfg_reg.zero_point     <= cfg_data[ZP_W-1:0];
                CFG_SCALE:          cfg_reg.scale          <= cfg_data[SCL_W-1:0];
                CFG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[HYS_W-1:0];
                CFG_PRESS_DISTANCE: cfg_reg.press_distance <= cfg_data[POS_W-1:0];
                CFG_LIFT_DISTANCE:  cfg_reg.lift_distance  <= cfg_data[RLS_W-1:0];
                CFG_PRESS_SPEED:    cfg_reg.press_speed    <= cfg_data[SPD_W-1:0];
                CFG_LIFT_SPEED:     cfg_reg.lift_speed     <= cfg_data[SPD_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (load_out)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (load_a && in_valid)
        begin
            raw_reg <= raw_sample;
        end
        if (load_out && a_valid_reg)
        begin
            pressed_reg  <= pressed_next;
            edge_reg     <= edge_next;
            position_reg <= pos_next;
        end
    end

    // Multiply by the reciprocal scale and saturate.
    akrt_norm u_norm (
        .raw (raw_reg),
        .cfg (cfg_reg),
        .pos (pos_next)
    );

    // Key state update, advanced once per sample that leaves the input
    // register.
    akrt_trig u_trig (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (load_out & a_valid_reg),
        .cfg          (cfg_reg),
        .pos          (pos_next),
        .pressed_next (pressed_next),
        .edge_next    (edge_next)
    );

    assign out_valid  = out_valid_reg;
    assign pressed    = pressed_reg;
    assign press_edge = edge_reg;
    assign position   = position_reg;

endmodule
